### rtl/mcat_pkg.sv
// package for the minute clock alarm and wake controller
// types, command and register codes, widths and the periodic-minute table
// no dependencies
package mcat_pkg;

    localparam int MAX_TIMERS      = 3;
    localparam int MAX_ALARMS      = 4;
    localparam int NUM_TIMERS_DEF  = 3;
    localparam int NUM_ALARMS_DEF  = 4;
    localparam int PERIODIC_DEF    = 5;

    localparam int HOUR_W          = 5;
    localparam int MINUTE_W        = 6;
    localparam int CMD_W           = 3;
    localparam int TSEL_W          = 2;
    localparam int TIMER_W         = 16;
    localparam int REASON_W        = 3;
    localparam int ALARM_W         = 11;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int S_DATA_W        = 32;
    localparam int M_DATA_W        = 32;

    localparam logic [HOUR_W-1:0]   LAST_HOUR   = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] LAST_MINUTE = MINUTE_W'(59);

    localparam logic [ALARM_W-1:0]  ALARM0_RESET = ALARM_W'(512);

    localparam logic [REASON_W-1:0] REASON_TIMER    = 3'b001;
    localparam logic [REASON_W-1:0] REASON_ALARM    = 3'b010;
    localparam logic [REASON_W-1:0] REASON_PERIODIC = 3'b100;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_SET_TIME = 3'd1,
        CMD_LOAD     = 3'd2,
        CMD_CANCEL   = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_ALARM0 = 3'd0,
        REG_ALARM1 = 3'd1,
        REG_ALARM2 = 3'd2,
        REG_ALARM3 = 3'd3,
        REG_ENABLE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HOUR_W-1:0]   new_hour;
        logic [MINUTE_W-1:0] new_minute;
        logic [TSEL_W-1:0]   timer_select;
        logic [TIMER_W-1:0]  timer_minutes;
    } t_item;

    typedef struct packed {
        logic [MAX_ALARMS-1:0][ALARM_W-1:0] alarm_time;
        logic [MAX_ALARMS-1:0]              enable_mask;
    } t_cfg;

    typedef struct packed {
        logic [MAX_TIMERS-1:0] running_timers;
        logic [MAX_ALARMS-1:0] fired_alarms;
        logic                  wake_request;
        logic [REASON_W-1:0]   latched_reason;
        logic [REASON_W-1:0]   step_reason;
        logic [MINUTE_W-1:0]   clock_minute;
        logic [HOUR_W-1:0]     clock_hour;
    } t_result;

    // one bit per minute value, set where the minute is a multiple of the period
    function automatic logic [63:0] periodic_mask(input int unsigned period);
        logic [63:0] m;
        int unsigned k;
        m = '0;
        k = 0;
        while (k < 64) begin
            m[6'(k)] = 1'b1;
            k = k + period;
        end
        return m;
    endfunction

endpackage

### rtl/mcat_cfg_regs.sv
// configuration registers: alarm times and alarm enable mask on an apb-style port
// depends on mcat_pkg
module mcat_cfg_regs import mcat_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [MAX_ALARMS-1:0][ALARM_W-1:0] r_alarm;
    logic [MAX_ALARMS-1:0]              r_enable;
    logic                               wr_en;
    logic [2:0]                         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm[0] <= ALARM0_RESET;
            r_alarm[1] <= '0;
            r_alarm[2] <= '0;
            r_alarm[3] <= '0;
            r_enable   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ALARM0: r_alarm[0] <= pwdata[ALARM_W-1:0];
                REG_ALARM1: r_alarm[1] <= pwdata[ALARM_W-1:0];
                REG_ALARM2: r_alarm[2] <= pwdata[ALARM_W-1:0];
                REG_ALARM3: r_alarm[3] <= pwdata[ALARM_W-1:0];
                REG_ENABLE: r_enable   <= pwdata[MAX_ALARMS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ALARM0: prdata = APB_DATA_W'(r_alarm[0]);
            REG_ALARM1: prdata = APB_DATA_W'(r_alarm[1]);
            REG_ALARM2: prdata = APB_DATA_W'(r_alarm[2]);
            REG_ALARM3: prdata = APB_DATA_W'(r_alarm[3]);
            REG_ENABLE: prdata = APB_DATA_W'(r_enable);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.alarm_time  = r_alarm;
    assign o_cfg.enable_mask = r_enable;

endmodule

### rtl/mcat_core.sv
// clock, countdown timers, alarm match and wake state; one item per cycle while i_advance is high
// depends on mcat_pkg
module mcat_core import mcat_pkg::*; #(
    parameter int NUM_TIMERS       = NUM_TIMERS_DEF,
    parameter int NUM_ALARMS       = NUM_ALARMS_DEF,
    parameter int PERIODIC_MINUTES = PERIODIC_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam logic [63:0] PERIODIC_HITS = periodic_mask(PERIODIC_MINUTES);

    logic [HOUR_W-1:0]     r_hour,   n_hour;
    logic [MINUTE_W-1:0]   r_minute, n_minute;
    logic [TIMER_W-1:0]    r_remaining [NUM_TIMERS];
    logic [TIMER_W-1:0]    n_remaining [NUM_TIMERS];
    logic [MAX_TIMERS-1:0] r_active,   n_active;
    logic [MAX_ALARMS-1:0] r_fired,    n_fired;
    logic                  r_wake,     n_wake;
    logic [REASON_W-1:0]   r_cause,    n_cause;
    logic [REASON_W-1:0]   reason;
    logic [HOUR_W-1:0]     tick_hour;
    logic [MINUTE_W-1:0]   tick_minute;
    logic [TIMER_W-1:0]    dec_value;

    // next clock value on a tick
    always_comb begin
        if (r_minute == LAST_MINUTE) begin
            tick_minute = '0;
            tick_hour   = (r_hour == LAST_HOUR) ? '0 : r_hour + HOUR_W'(1);
        end else begin
            tick_minute = r_minute + MINUTE_W'(1);
            tick_hour   = r_hour;
        end
    end

    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_active = r_active;
        n_fired  = r_fired;
        n_wake   = r_wake;
        n_cause  = r_cause;
        reason   = '0;
        dec_value = '0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            n_remaining[k] = r_remaining[k];
        end
        case (i_item.cmd)
            CMD_TICK: begin
                n_hour   = tick_hour;
                n_minute = tick_minute;
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    if (r_active[k]) begin
                        dec_value = (r_remaining[k] != '0) ?
                                    r_remaining[k] - TIMER_W'(1) : '0;
                        n_remaining[k] = dec_value;
                        if (dec_value == '0) begin
                            n_active[k] = 1'b0;
                            reason = reason | REASON_TIMER;
                        end
                    end
                end
                for (int k = 0; k < NUM_ALARMS; k++) begin
                    if (i_cfg.enable_mask[k] &&
                        i_cfg.alarm_time[k][ALARM_W-1:MINUTE_W] == tick_hour &&
                        i_cfg.alarm_time[k][MINUTE_W-1:0] == tick_minute) begin
                        n_fired[k] = 1'b1;
                        reason = reason | REASON_ALARM;
                    end
                end
                if (PERIODIC_HITS[tick_minute]) begin
                    reason = reason | REASON_PERIODIC;
                end
                if (reason != '0) begin
                    n_wake  = 1'b1;
                    n_cause = reason;
                end
            end
            CMD_SET_TIME: begin
                n_hour   = (i_item.new_hour > LAST_HOUR) ? LAST_HOUR : i_item.new_hour;
                n_minute = (i_item.new_minute > LAST_MINUTE) ?
                           LAST_MINUTE : i_item.new_minute;
            end
            CMD_LOAD: begin
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    if (i_item.timer_select == TSEL_W'(k)) begin
                        n_remaining[k] = i_item.timer_minutes;
                        n_active[k]    = 1'b1;
                    end
                end
            end
            CMD_CANCEL: begin
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    if (i_item.timer_select == TSEL_W'(k)) begin
                        n_remaining[k] = '0;
                        n_active[k]    = 1'b0;
                    end
                end
            end
            CMD_CLEAR: begin
                n_wake  = 1'b0;
                n_cause = '0;
                n_fired = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour   <= '0;
            r_minute <= '0;
            r_active <= '0;
            r_fired  <= '0;
            r_wake   <= 1'b0;
            r_cause  <= '0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_remaining[k] <= '0;
            end
        end else if (i_advance) begin
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_active <= n_active;
            r_fired  <= n_fired;
            r_wake   <= n_wake;
            r_cause  <= n_cause;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_remaining[k] <= n_remaining[k];
            end
        end
    end

    assign o_result.clock_hour     = n_hour;
    assign o_result.clock_minute   = n_minute;
    assign o_result.step_reason    = reason;
    assign o_result.latched_reason = n_cause;
    assign o_result.wake_request   = n_wake;
    assign o_result.fired_alarms   = n_fired;
    assign o_result.running_timers = n_active;

    a_wake_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wake |-> r_cause != '0)
        else $error("wake flag set without a latched reason");

    a_clear_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.cmd == CMD_CLEAR |=> !r_wake && r_fired == '0)
        else $error("clear did not clear the wake status");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour <= LAST_HOUR && r_minute <= LAST_MINUTE)
        else $error("clock left its range");

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer_chk
        a_idle_timer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !r_active[g] |-> r_remaining[g] == '0)
            else $error("stopped timer holds a count");
    end

endmodule

### rtl/minute_clock_alarm_timer_wake.sv
// top level: minute clock with alarms, countdown timers and wake request
// depends on mcat_pkg, mcat_cfg_regs, mcat_core
//
// channel   | dir | handshake              | payload
// s_axis    | in  | tvalid / tready        | tuser: cmd; tdata: hour, minute, select, minutes
// m_axis    | out | tvalid / tready        | tdata: clock, reasons, wake, alarms, timers
// apb       | in  | psel / penable / pready| alarm times and enable mask
//
// an item passes from input to result through the input register, then the result register
// one item per cycle sustained while m_axis_tready stays high; the clock and timer state update in a single pass
// reset is synchronous; alarm 0 comes up at 08:00, all else but the data registers at zero
// a stalled result holds in the output register while one more item waits at the input
module minute_clock_alarm_timer_wake import mcat_pkg::*; #(
    parameter int NUM_TIMERS       = NUM_TIMERS_DEF,
    parameter int NUM_ALARMS       = NUM_ALARMS_DEF,
    parameter int PERIODIC_MINUTES = PERIODIC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // hour[4:0], minute[10:5], timer_select[12:11], timer_minutes[28:13], zeros
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // cmd[2:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hour[4:0], minute[10:5], step_reason[13:11], latched_reason[16:14],
    // wake_request[17], fired_alarms[21:18], running_timers[24:22], zeros
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_item   s_item;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result core_result;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;

    mcat_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign s_item.cmd           = s_axis_tuser;
    assign s_item.new_hour      = s_axis_tdata[4:0];
    assign s_item.new_minute    = s_axis_tdata[10:5];
    assign s_item.timer_select  = s_axis_tdata[12:11];
    assign s_item.timer_minutes = s_axis_tdata[28:13];

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= s_item;
        end
    end

    mcat_core #(
        .NUM_TIMERS       (NUM_TIMERS),
        .NUM_ALARMS       (NUM_ALARMS),
        .PERIODIC_MINUTES (PERIODIC_MINUTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'(r_out);

endmodule
